[src/pszt_pkg.sv]
// pszt_pkg: shared types and constants of the pair spread z-score trader
// used by pszt_ctrl, pszt_datapath and pair_spread_zscore_trader
package pszt_pkg;

    localparam int WINDOW_LENGTH_DEF = 20;

    localparam int SPREAD_W = 26;
    localparam int SUM_W    = 32;
    localparam int SQSUM_W  = 58;
    localparam int POS_W    = 17;
    localparam int CASH_W   = 48;
    localparam int MUL_W    = 33;
    localparam int PROD_W   = 2 * MUL_W;

    localparam logic [7:0]  ENTRY_RESET = 8'd32;
    localparam logic [7:0]  EXIT_RESET  = 8'd8;
    localparam logic [15:0] QTY_RESET   = 16'd100;
    localparam logic [39:0] CASH_RESET  = 40'd25600000;

    localparam logic [1:0] REG_ENTRY = 2'd0;
    localparam logic [1:0] REG_EXIT  = 2'd1;
    localparam logic [1:0] REG_QTY   = 2'd2;
    localparam logic [1:0] REG_CASH  = 2'd3;

    localparam logic [1:0] SIG_NONE       = 2'd0;
    localparam logic [1:0] SIG_SHORT_LONG = 2'd1;
    localparam logic [1:0] SIG_LONG_SHORT = 2'd2;
    localparam logic [1:0] SIG_CLOSE      = 2'd3;

    localparam logic [1:0] INST_FIRST  = 2'd0;
    localparam logic [1:0] INST_SECOND = 2'd1;

    localparam logic [3:0] MUL_NONE   = 4'd0;
    localparam logic [3:0] MUL_OLD    = 4'd1;
    localparam logic [3:0] MUL_NEW    = 4'd2;
    localparam logic [3:0] MUL_SUM    = 4'd3;
    localparam logic [3:0] MUL_AD     = 4'd4;
    localparam logic [3:0] MUL_ENT_LO = 4'd5;
    localparam logic [3:0] MUL_ENT_HI = 4'd6;
    localparam logic [3:0] MUL_EXT_LO = 4'd7;
    localparam logic [3:0] MUL_EXT_HI = 4'd8;
    localparam logic [3:0] MUL_LEG1   = 4'd9;
    localparam logic [3:0] MUL_LEG2   = 4'd10;

    typedef struct packed {
        logic       latch_in;
        logic       load_levels;
        logic       sub_old;
        logic       push;
        logic       load_d;
        logic       load_v;
        logic       load_a2;
        logic       cmp_entry;
        logic       cmp_exit;
        logic       decide;
        logic       cash_add;
        logic       pos_update;
        logic       out_load;
        logic [3:0] mul_sel;
    } cmd_t;

    typedef struct packed {
        logic both_seen;
        logic fill_ready;
        logic v_zero;
        logic trade;
    } sts_t;

endpackage

[src/pszt_ctrl.sv]
// pszt_ctrl: sequencer of the trader, one item at a time
// depends on pszt_pkg; drives the pszt_datapath command struct
module pszt_ctrl
    import pszt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_CHECK  = 5'd1;
    localparam logic [4:0] ST_OLDSQ  = 5'd2;
    localparam logic [4:0] ST_NEWSQ  = 5'd3;
    localparam logic [4:0] ST_PUSH   = 5'd4;
    localparam logic [4:0] ST_SUMSQ  = 5'd5;
    localparam logic [4:0] ST_VAR    = 5'd6;
    localparam logic [4:0] ST_A2     = 5'd7;
    localparam logic [4:0] ST_EHI    = 5'd8;
    localparam logic [4:0] ST_ECMP   = 5'd9;
    localparam logic [4:0] ST_XHI    = 5'd10;
    localparam logic [4:0] ST_XCMP   = 5'd11;
    localparam logic [4:0] ST_DECIDE = 5'd12;
    localparam logic [4:0] ST_TRADE1 = 5'd13;
    localparam logic [4:0] ST_TRADE2 = 5'd14;
    localparam logic [4:0] ST_TRADE3 = 5'd15;
    localparam logic [4:0] ST_OUT    = 5'd16;

    logic [4:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.load_levels = 1'b1;
                state_next = sts.both_seen ? ST_OLDSQ : ST_OUT;
            end
            ST_OLDSQ:
            begin
                cmd.mul_sel = MUL_OLD;
                state_next  = ST_NEWSQ;
            end
            ST_NEWSQ:
            begin
                cmd.sub_old = 1'b1;
                cmd.mul_sel = MUL_NEW;
                state_next  = ST_PUSH;
            end
            ST_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = sts.fill_ready ? ST_SUMSQ : ST_OUT;
            end
            ST_SUMSQ:
            begin
                cmd.load_d  = 1'b1;
                cmd.mul_sel = MUL_SUM;
                state_next  = ST_VAR;
            end
            ST_VAR:
            begin
                cmd.load_v  = 1'b1;
                cmd.mul_sel = MUL_AD;
                state_next  = ST_A2;
            end
            ST_A2:
            begin
                cmd.load_a2 = 1'b1;
                cmd.mul_sel = MUL_ENT_LO;
                state_next  = sts.v_zero ? ST_OUT : ST_EHI;
            end
            ST_EHI:
            begin
                cmd.mul_sel = MUL_ENT_HI;
                state_next  = ST_ECMP;
            end
            ST_ECMP:
            begin
                cmd.cmp_entry = 1'b1;
                cmd.mul_sel   = MUL_EXT_LO;
                state_next    = ST_XHI;
            end
            ST_XHI:
            begin
                cmd.mul_sel = MUL_EXT_HI;
                state_next  = ST_XCMP;
            end
            ST_XCMP:
            begin
                cmd.cmp_exit = 1'b1;
                state_next   = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = sts.trade ? ST_TRADE1 : ST_OUT;
            end
            ST_TRADE1:
            begin
                cmd.mul_sel = MUL_LEG1;
                state_next  = ST_TRADE2;
            end
            ST_TRADE2:
            begin
                cmd.cash_add = 1'b1;
                cmd.mul_sel  = MUL_LEG2;
                state_next   = ST_TRADE3;
            end
            ST_TRADE3:
            begin
                cmd.cash_add   = 1'b1;
                cmd.pos_update = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[src/pszt_datapath.sv]
// pszt_datapath: mids, spread window, shared multiplier, score compares, trades
// depends on pszt_pkg; sequenced by pszt_ctrl, holds the configuration registers
module pszt_datapath
    import pszt_pkg::*;
#(
    parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    input  logic [1:0]               instrument,
    input  logic [23:0]              bid_price,
    input  logic [23:0]              ask_price,
    input  logic                     cfg_wr,
    input  logic [1:0]               cfg_idx,
    input  logic [63:0]              cfg_wdata,
    output logic [63:0]              cfg_rdata,
    output logic [1:0]               signal,
    output logic                     score_valid,
    output logic signed [POS_W-1:0]  first_position,
    output logic signed [POS_W-1:0]  second_position,
    output logic signed [CASH_W-1:0] cash_balance
);

    localparam int PTR_W  = $clog2(WINDOW_LENGTH);
    localparam int FILL_W = $clog2(WINDOW_LENGTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(WINDOW_LENGTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_LENGTH);
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WINDOW_LENGTH - 1);
    localparam logic signed [MUL_W-1:0] WIN_S = MUL_W'(WINDOW_LENGTH);
    localparam logic signed [CASH_W-1:0] CASH_MAX = {1'b0, {(CASH_W-1){1'b1}}};
    localparam logic signed [CASH_W-1:0] CASH_MIN = {1'b1, {(CASH_W-1){1'b0}}};

    // configuration
    logic [7:0]  entry_reg, exit_reg;
    logic [15:0] qty_reg;
    logic [39:0] start_reg;

    // item
    logic [23:0] bid_reg, ask_reg;
    logic [24:0] fm_reg, sm_reg;
    logic        fseen_reg, sseen_reg;

    // window
    logic signed [SPREAD_W-1:0] ring_mem [WINDOW_LENGTH];
    logic [PTR_W-1:0]           ptr_reg;
    logic [FILL_W-1:0]          fill_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [SQSUM_W-1:0]         sqsum_reg;

    // score
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic [47:0]              acc_reg;
    logic signed [MUL_W-1:0]  d_reg;
    logic [63:0]              v_reg;
    logic [63:0]              a2_reg;
    logic [15:0]              e2_reg, x2_reg;
    logic                     gt_e_reg, lt_x_reg;

    // trading
    logic signed [POS_W-1:0]  hf_reg, hs_reg;
    logic signed [CASH_W-1:0] cash_reg;
    logic [1:0]               sig_reg;
    logic                     valid_reg;

    logic [1:0]               out_sig_reg;
    logic                     out_valid_reg;
    logic signed [POS_W-1:0]  out_hf_reg, out_hs_reg;
    logic signed [CASH_W-1:0] out_cash_reg;

    logic                       full;
    logic signed [SPREAD_W-1:0] spread, old_val;
    logic signed [MUL_W-1:0]    w_s, d_next, ad;
    logic [63:0]                v_next;
    logic [79:0]                lhs, rhs;
    logic signed [MUL_W-1:0]    q_pos, q_neg, bid_s, ask_s, hf_px, hs_px;
    logic [1:0]                 sig_next;
    logic signed [CASH_W:0]     cash_sum;
    logic signed [CASH_W-1:0]   cash_next;

    assign full    = (fill_reg == FILL_FULL);
    assign spread  = $signed({1'b0, fm_reg}) - $signed({1'b0, sm_reg});
    assign old_val = full ? ring_mem[ptr_reg] : '0;
    assign w_s     = MUL_W'(spread) * WIN_S;
    assign d_next  = w_s - MUL_W'(sum_reg);
    assign ad      = d_reg[MUL_W-1] ? -d_reg : d_reg;
    assign v_next  = 64'(sqsum_reg) * 64'(WINDOW_LENGTH) - prod_reg[63:0];
    assign lhs     = {8'd0, a2_reg, 8'd0};
    assign rhs     = {prod_reg[47:0], 32'd0} + {32'd0, acc_reg};

    assign q_pos = MUL_W'($signed({1'b0, qty_reg}));
    assign q_neg = -q_pos;
    assign bid_s = MUL_W'($signed({1'b0, bid_reg}));
    assign ask_s = MUL_W'($signed({1'b0, ask_reg}));
    assign hf_px = hf_reg[POS_W-1] ? ask_s : bid_s;
    assign hs_px = hs_reg[POS_W-1] ? ask_s : bid_s;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            MUL_OLD:
            begin
                mul_a = MUL_W'(old_val);
                mul_b = MUL_W'(old_val);
            end
            MUL_NEW:
            begin
                mul_a = MUL_W'(spread);
                mul_b = MUL_W'(spread);
            end
            MUL_SUM:
            begin
                mul_a = MUL_W'(sum_reg);
                mul_b = MUL_W'(sum_reg);
            end
            MUL_AD:
            begin
                mul_a = ad;
                mul_b = ad;
            end
            MUL_ENT_LO:
            begin
                mul_a = MUL_W'($signed({1'b0, e2_reg}));
                mul_b = $signed({1'b0, v_reg[31:0]});
            end
            MUL_ENT_HI:
            begin
                mul_a = MUL_W'($signed({1'b0, e2_reg}));
                mul_b = $signed({1'b0, v_reg[63:32]});
            end
            MUL_EXT_LO:
            begin
                mul_a = MUL_W'($signed({1'b0, x2_reg}));
                mul_b = $signed({1'b0, v_reg[31:0]});
            end
            MUL_EXT_HI:
            begin
                mul_a = MUL_W'($signed({1'b0, x2_reg}));
                mul_b = $signed({1'b0, v_reg[63:32]});
            end
            MUL_LEG1:
            begin
                priority if (sig_reg == SIG_SHORT_LONG)
                begin
                    mul_a = q_pos;
                    mul_b = bid_s;
                end
                else if (sig_reg == SIG_LONG_SHORT)
                begin
                    mul_a = q_neg;
                    mul_b = ask_s;
                end
                else
                begin
                    mul_a = MUL_W'(hf_reg);
                    mul_b = hf_px;
                end
            end
            MUL_LEG2:
            begin
                priority if (sig_reg == SIG_SHORT_LONG)
                begin
                    mul_a = q_neg;
                    mul_b = ask_s;
                end
                else if (sig_reg == SIG_LONG_SHORT)
                begin
                    mul_a = q_pos;
                    mul_b = bid_s;
                end
                else
                begin
                    mul_a = MUL_W'(hs_reg);
                    mul_b = hs_px;
                end
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        priority if (!d_reg[MUL_W-1] && (d_reg != '0) && gt_e_reg && (hf_reg == '0))
        begin
            sig_next = SIG_SHORT_LONG;
        end
        else if (d_reg[MUL_W-1] && gt_e_reg && (hf_reg == '0))
        begin
            sig_next = SIG_LONG_SHORT;
        end
        else if ((hf_reg != '0) && lt_x_reg)
        begin
            sig_next = SIG_CLOSE;
        end
        else
        begin
            sig_next = SIG_NONE;
        end
    end

    always_comb
    begin
        cash_sum = {cash_reg[CASH_W-1], cash_reg} + $signed(prod_reg[CASH_W:0]);
        if (cash_sum[CASH_W] != cash_sum[CASH_W-1])
        begin
            cash_next = cash_sum[CASH_W] ? CASH_MIN : CASH_MAX;
        end
        else
        begin
            cash_next = cash_sum[CASH_W-1:0];
        end
    end

    assign sts.both_seen  = fseen_reg && sseen_reg;
    assign sts.fill_ready = (fill_reg >= FILL_LAST);
    assign sts.v_zero     = (v_reg == '0);
    assign sts.trade      = (sig_next != SIG_NONE);

    always_comb
    begin
        unique case (cfg_idx)
            REG_ENTRY: cfg_rdata = 64'(entry_reg);
            REG_EXIT:  cfg_rdata = 64'(exit_reg);
            REG_QTY:   cfg_rdata = 64'(qty_reg);
            REG_CASH:  cfg_rdata = 64'(start_reg);
            default:   cfg_rdata = '0;
        endcase
    end

    // control and configuration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= ENTRY_RESET;
            exit_reg  <= EXIT_RESET;
            qty_reg   <= QTY_RESET;
            start_reg <= CASH_RESET;
            cash_reg  <= CASH_W'(CASH_RESET);
            fm_reg    <= '0;
            sm_reg    <= '0;
            fseen_reg <= 1'b0;
            sseen_reg <= 1'b0;
            ptr_reg   <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
            sqsum_reg <= '0;
            hf_reg    <= '0;
            hs_reg    <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    REG_ENTRY: entry_reg <= cfg_wdata[7:0];
                    REG_EXIT:  exit_reg  <= cfg_wdata[7:0];
                    REG_QTY:   qty_reg   <= cfg_wdata[15:0];
                    REG_CASH:
                    begin
                        start_reg <= cfg_wdata[39:0];
                        cash_reg  <= CASH_W'(cfg_wdata[39:0]);
                    end
                    default:
                    begin
                        start_reg <= start_reg;
                    end
                endcase
            end
            else if (cmd.cash_add)
            begin
                cash_reg <= cash_next;
            end
            if (cmd.latch_in)
            begin
                if (instrument == INST_FIRST)
                begin
                    fm_reg    <= 25'(bid_price) + 25'(ask_price);
                    fseen_reg <= 1'b1;
                end
                else if (instrument == INST_SECOND)
                begin
                    sm_reg    <= 25'(bid_price) + 25'(ask_price);
                    sseen_reg <= 1'b1;
                end
            end
            if (cmd.sub_old)
            begin
                sqsum_reg <= sqsum_reg - prod_reg[SQSUM_W-1:0];
            end
            if (cmd.push)
            begin
                sqsum_reg <= sqsum_reg + prod_reg[SQSUM_W-1:0];
                sum_reg   <= sum_reg - SUM_W'(old_val) + SUM_W'(spread);
                ptr_reg   <= (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
                if (!full)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (cmd.pos_update)
            begin
                unique case (sig_reg)
                    SIG_SHORT_LONG:
                    begin
                        hf_reg <= hf_reg - POS_W'(qty_reg);
                        hs_reg <= hs_reg + POS_W'(qty_reg);
                    end
                    SIG_LONG_SHORT:
                    begin
                        hf_reg <= hf_reg + POS_W'(qty_reg);
                        hs_reg <= hs_reg - POS_W'(qty_reg);
                    end
                    SIG_CLOSE:
                    begin
                        hf_reg <= '0;
                        hs_reg <= '0;
                    end
                    default:
                    begin
                        hf_reg <= hf_reg;
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        acc_reg  <= prod_reg[47:0];
        if (cmd.latch_in)
        begin
            bid_reg   <= bid_price;
            ask_reg   <= ask_price;
            sig_reg   <= SIG_NONE;
            valid_reg <= 1'b0;
        end
        if (cmd.load_levels)
        begin
            e2_reg <= 16'(entry_reg) * 16'(entry_reg);
            x2_reg <= 16'(exit_reg) * 16'(exit_reg);
        end
        if (cmd.push)
        begin
            ring_mem[ptr_reg] <= spread;
        end
        if (cmd.load_d)
        begin
            d_reg <= d_next;
        end
        if (cmd.load_v)
        begin
            v_reg <= v_next;
        end
        if (cmd.load_a2)
        begin
            a2_reg <= prod_reg[63:0];
        end
        if (cmd.cmp_entry)
        begin
            gt_e_reg <= (lhs > rhs);
        end
        if (cmd.cmp_exit)
        begin
            lt_x_reg <= (lhs < rhs);
        end
        if (cmd.decide)
        begin
            sig_reg   <= sig_next;
            valid_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            out_sig_reg   <= sig_reg;
            out_valid_reg <= valid_reg;
            out_hf_reg    <= hf_reg;
            out_hs_reg    <= hs_reg;
            out_cash_reg  <= cash_reg;
        end
    end

    assign signal          = out_sig_reg;
    assign score_valid     = out_valid_reg;
    assign first_position  = out_hf_reg;
    assign second_position = out_hs_reg;
    assign cash_balance    = out_cash_reg;

endmodule

[src/pair_spread_zscore_trader.sv]
// pair_spread_zscore_trader: top level of the pairs trader on a rolling z-score
// depends on pszt_pkg, pszt_ctrl and pszt_datapath
//
// usage:
//   s_* carries one quote item: instrument in s_tuser, bid and ask in s_tdata.
//   m_* returns exactly one result item per quote: signal and score_valid in
//   m_tuser, positions and cash in m_tdata. apb port sets entry/exit levels,
//   trade quantity and starting cash; writing starting cash also reloads the
//   cash balance. the user writes only while idle; the block does not enforce it.
// timing:
//   one item at a time, set by the single shared 33x33 multiplier that the
//   sequencer steps through the squares, score compares and trade legs.
//   an item ends early before both legs are seen, while the window fills, or
//   on zero variance; otherwise it runs both score compares, then any trade legs.
//   after registering the result the sequencer goes idle and takes the next item.
// reset:
//   clears mids, window, positions; cash and registers go to their defaults.
// stall:
//   a result waits in the output register; the next item is accepted and
//   worked on, and holds at its end until the output register frees.
module pair_spread_zscore_trader
    import pszt_pkg::*;
#(
    parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // bid_price[23:0], ask_price[47:24]
    input  logic [1:0]  s_tuser,   // instrument[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // first_position[16:0], second_position[33:17],
                                   // cash_balance[81:34], zero fill
    output logic [2:0]  m_tuser,   // signal[1:0], score_valid[2]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    cmd_t cmd;
    sts_t sts;

    logic [1:0]               signal;
    logic                     score_valid;
    logic signed [POS_W-1:0]  first_position, second_position;
    logic signed [CASH_W-1:0] cash_balance;
    logic                     cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    pszt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pszt_datapath #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .instrument      (s_tuser),
        .bid_price       (s_tdata[23:0]),
        .ask_price       (s_tdata[47:24]),
        .cfg_wr          (cfg_wr),
        .cfg_idx         (paddr[4:3]),
        .cfg_wdata       (pwdata),
        .cfg_rdata       (prdata),
        .signal          (signal),
        .score_valid     (score_valid),
        .first_position  (first_position),
        .second_position (second_position),
        .cash_balance    (cash_balance)
    );

    assign m_tdata = {6'd0, cash_balance, second_position, first_position};
    assign m_tuser = {score_valid, signal};

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while another is in work");

    a_signal_needs_score: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[1:0] != SIG_NONE)) |-> m_tuser[2])
        else $error("trade signal without a valid score");

    a_legs_balanced: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[16:0] + m_tdata[33:17]) == 17'd0))
        else $error("pair legs out of balance");

endmodule
